FILE: sv/lbmc_pkg.sv
`timescale 1ns / 1ps

package lbmc_pkg;

  // Field widths fixed by the interface
  localparam int OP_W    = 3;
  localparam int MODE_W  = 2;
  localparam int COUNT_W = 8;

  // Input operation codes
  localparam logic [OP_W-1:0] OP_TICK      = 3'd0;
  localparam logic [OP_W-1:0] OP_REQ_OFF   = 3'd1;
  localparam logic [OP_W-1:0] OP_REQ_SOLID = 3'd2;
  localparam logic [OP_W-1:0] OP_REQ_BLINK = 3'd3;
  localparam logic [OP_W-1:0] OP_REQ_BLINKN = 3'd4;

  // LED modes
  localparam logic [MODE_W-1:0] MODE_OFF     = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SOLID   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_BLINK   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_BLINK_N = 2'd3;

  // One result word
  typedef struct packed {
    logic               led_level;
    logic [MODE_W-1:0]  active_mode;
    logic [COUNT_W-1:0] blinks_left;
  } result_t;

endpackage

FILE: sv/led_blink_mode_controller.sv
`timescale 1ns / 1ps

// Channel | Handshake          | Fields
// --------+--------------------+-----------------------------------------
// input   | in_valid, in_stall | op, half_period, blink_count
// output  | out_valid, out_stall | led_level, active_mode, blinks_left
//
// One word is accepted per cycle unless in_stall; each result lands in the
// output register, or the skid entry on a stall. Mode, period and countdown
// update is a single pass of compares and two decrements between registers.
// Synchronous reset: LED dark, mode off, timer stopped, no result held.
// A two-entry output buffer lets one more word in while a result is stalled;
// in_stall rises only when both entries are full.

module led_blink_mode_controller #(
  parameter int PERIOD_BITS = 24
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [lbmc_pkg::OP_W-1:0]    op,
  input  logic [PERIOD_BITS-1:0]       half_period,
  input  logic [lbmc_pkg::COUNT_W-1:0] blink_count,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         led_level,
  output logic [lbmc_pkg::MODE_W-1:0]  active_mode,
  output logic [lbmc_pkg::COUNT_W-1:0] blinks_left
);

  import lbmc_pkg::*;

  localparam logic [PERIOD_BITS-1:0] PERIOD_ONE = PERIOD_BITS'(1);

  // Controller state
  logic [MODE_W-1:0]      mode_now, mode_now_next;
  logic [PERIOD_BITS-1:0] period_now, period_now_next;
  logic [COUNT_W-1:0]     count_now, count_now_next;
  logic [MODE_W-1:0]      mode_after, mode_after_next;
  logic [PERIOD_BITS-1:0] period_after, period_after_next;
  logic [COUNT_W-1:0]     count_after, count_after_next;
  logic                   led_out, led_out_next;
  logic [PERIOD_BITS-1:0] countdown, countdown_next;
  logic                   timer_running, timer_running_next;

  // Output buffer
  result_t out_data;
  result_t skid_data;
  logic    skid_valid;
  result_t res;

  logic accept;
  logic out_ready;

  // Request decode
  logic                   is_req;
  logic [MODE_W-1:0]      req_m;
  logic [PERIOD_BITS-1:0] req_p;
  logic [COUNT_W-1:0]     req_c;

  // Work flags
  logic                   do_enter;
  logic [MODE_W-1:0]      enter_m;
  logic [PERIOD_BITS-1:0] enter_p;
  logic [COUNT_W-1:0]     enter_c;
  logic                   do_start;
  logic                   do_stop;
  logic [PERIOD_BITS-1:0] cd_dec;
  logic [COUNT_W-1:0]     count_dec;

  assign in_stall  = skid_valid;
  assign accept    = in_valid && !skid_valid;
  assign out_ready = !out_valid || !out_stall;

  // Map the operation onto a mode request
  always_comb begin
    is_req = 1'b1;
    req_m  = MODE_OFF;
    req_p  = period_now;
    req_c  = count_now;
    unique case (op)
      OP_REQ_OFF:   req_m = MODE_OFF;
      OP_REQ_SOLID: req_m = MODE_SOLID;
      OP_REQ_BLINK: begin
        req_m = MODE_BLINK;
        req_p = half_period;
      end
      OP_REQ_BLINKN: begin
        req_m = MODE_BLINK_N;
        req_p = half_period;
        req_c = blink_count;
      end
      default: is_req = 1'b0;
    endcase
  end

  // Next state for one word
  always_comb begin
    mode_now_next      = mode_now;
    period_now_next    = period_now;
    count_now_next     = count_now;
    mode_after_next    = mode_after;
    period_after_next  = period_after;
    count_after_next   = count_after;
    led_out_next       = led_out;
    countdown_next     = countdown;
    timer_running_next = timer_running;
    do_enter = 1'b0;
    enter_m  = req_m;
    enter_p  = req_p;
    enter_c  = req_c;
    do_start = 1'b0;
    do_stop  = 1'b0;
    cd_dec    = (countdown != '0) ? countdown - PERIOD_ONE : '0;
    count_dec = count_now - COUNT_W'(1);

    if (op == OP_TICK) begin
      // Advance the countdown, act on expiry
      if (timer_running) begin
        countdown_next = cd_dec;
        if (cd_dec == '0) begin
          timer_running_next = 1'b0;
          if (!led_out) begin
            led_out_next = 1'b1;
            do_start     = 1'b1;
          end else if (mode_now == MODE_BLINK_N && count_dec == '0) begin
            // Last blink: restore the saved mode
            count_now_next = '0;
            do_enter = 1'b1;
            enter_m  = mode_after;
            enter_p  = period_after;
            enter_c  = count_after;
          end else begin
            if (mode_now == MODE_BLINK_N) begin
              count_now_next = count_dec;
            end
            led_out_next = 1'b0;
            do_start     = 1'b1;
          end
        end
      end
    end else if (is_req) begin
      if (req_m == mode_now && req_m != MODE_BLINK_N) begin
        // Same mode: drop the request
      end else if (mode_now != MODE_BLINK_N) begin
        if (req_m == MODE_BLINK_N) begin
          mode_after_next   = mode_now;
          period_after_next = period_now;
          count_after_next  = count_now;
          mode_now_next     = MODE_BLINK_N;
          period_now_next   = req_p;
          count_now_next    = req_c;
          led_out_next      = 1'b1;
          do_start          = 1'b1;
        end else begin
          do_enter = 1'b1;
        end
      end else if (req_m == MODE_BLINK_N) begin
        // Restart blink N
        period_now_next = req_p;
        count_now_next  = req_c;
        led_out_next    = 1'b1;
        do_start        = 1'b1;
      end else if (count_now == '0) begin
        do_enter = 1'b1;
      end else begin
        // Hold the request until blink N ends
        mode_after_next   = req_m;
        period_after_next = req_p;
        count_after_next  = req_c;
      end
    end

    // Enter a mode
    if (do_enter) begin
      mode_now_next   = enter_m;
      period_now_next = enter_p;
      count_now_next  = enter_c;
      if (enter_m == MODE_OFF) begin
        led_out_next = 1'b0;
        do_stop      = 1'b1;
      end else if (enter_m == MODE_SOLID) begin
        led_out_next = 1'b1;
        do_stop      = 1'b1;
      end else begin
        led_out_next = 1'b1;
        do_start     = 1'b1;
      end
    end

    // Load or clear the countdown
    if (do_stop) begin
      countdown_next     = '0;
      timer_running_next = 1'b0;
    end else if (do_start) begin
      countdown_next     = (period_now_next != '0) ? period_now_next : PERIOD_ONE;
      timer_running_next = 1'b1;
    end
  end

  // Result word for this item
  always_comb begin
    res.led_level   = led_out_next;
    res.active_mode = mode_now_next;
    res.blinks_left = (mode_now_next == MODE_BLINK_N) ? count_now_next : '0;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode_now      <= MODE_OFF;
      period_now    <= '0;
      count_now     <= '0;
      mode_after    <= MODE_OFF;
      period_after  <= '0;
      count_after   <= '0;
      led_out       <= 1'b0;
      countdown     <= '0;
      timer_running <= 1'b0;
    end else if (accept) begin
      mode_now      <= mode_now_next;
      period_now    <= period_now_next;
      count_now     <= count_now_next;
      mode_after    <= mode_after_next;
      period_after  <= period_after_next;
      count_after   <= count_after_next;
      led_out       <= led_out_next;
      countdown     <= countdown_next;
      timer_running <= timer_running_next;
    end
  end

  // Output register and skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_ready) begin
      if (skid_valid) begin
        out_data   <= skid_data;
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else if (accept) begin
        out_data  <= res;
        out_valid <= 1'b1;
      end else begin
        out_valid <= 1'b0;
      end
    end else if (accept) begin
      skid_data  <= res;
      skid_valid <= 1'b1;
    end
  end

  assign led_level   = out_data.led_level;
  assign active_mode = out_data.active_mode;
  assign blinks_left = out_data.blinks_left;

endmodule
